// ===== sv/swot_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swot_pkg;

  localparam int unsigned NumVals = 16;
  localparam int unsigned NibW    = 4;
  localparam int unsigned WtW     = 3;
  localparam int unsigned CntW    = 5;
  localparam int unsigned NumLvls = 3;

  typedef logic [NibW-1:0]              nib_t;
  typedef logic [WtW-1:0]               wt_t;
  typedef logic [CntW-1:0]              cnt_t;
  typedef logic [NumVals-1:0]           vec_t;
  typedef logic [NumVals-1:0][NibW-1:0] sbox_t;
  typedef logic [NumVals-1:0][NumVals-1:0] match_t;

  localparam sbox_t SboxReset = 64'h21748FE3DA09B65C;

  typedef enum logic {
    MODE_DDT = 1'b0,
    MODE_LAT = 1'b1
  } mode_e;

  typedef enum logic {
    REG_SBOX = 1'b0,
    REG_MODE = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    LVL_0    = 2'd0,
    LVL_1    = 2'd1,
    LVL_2    = 2'd2,
    LVL_NONE = 2'd3
  } lvl_e;

  // Equal weights leave in Hamming order of the output value.
  localparam nib_t TieOrder [NumVals] = '{
    4'h0, 4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h5, 4'h6,
    4'h9, 4'ha, 4'hc, 4'h7, 4'hb, 4'hd, 4'he, 4'hf
  };

  typedef struct packed {
    logic [NumLvls-1:0][NumVals-1:0] mask;   // bit p: TieOrder[p] has this level
    logic [NumLvls-1:0][WtW-1:0]     rel_w;
    wt_t                             min_w;
    wt_t                             max_w;
  } row_t;

  function automatic logic parity4(input nib_t v);
    return ^v;
  endfunction

  function automatic cnt_t popcount16(input vec_t v);
    cnt_t c;
    c = '0;
    for (int i = 0; i < NumVals; i++) begin
      c = c + cnt_t'(v[i]);
    end
    return c;
  endfunction

  function automatic lvl_e count_level(input cnt_t c, input mode_e mode);
    lvl_e l;
    l = LVL_NONE;
    if (mode == MODE_DDT) begin
      if (c == cnt_t'(16)) l = LVL_0;
      else if (c == cnt_t'(4)) l = LVL_1;
      else if (c == cnt_t'(2)) l = LVL_2;
    end else begin
      if (c == cnt_t'(0) || c == cnt_t'(16)) l = LVL_0;
      else if (c == cnt_t'(4) || c == cnt_t'(12)) l = LVL_1;
      else if (c == cnt_t'(6) || c == cnt_t'(10)) l = LVL_2;
    end
    return l;
  endfunction

  function automatic wt_t lvl_weight(input lvl_e l, input mode_e mode);
    wt_t w;
    unique case (l)
      LVL_0:    w = wt_t'(0);
      LVL_1:    w = wt_t'(2);
      LVL_2:    w = (mode == MODE_LAT) ? wt_t'(4) : wt_t'(3);
      default:  w = wt_t'(0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/swot_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swot_in_if;
  import swot_pkg::*;
  logic valid;
  logic ready;
  nib_t input_value;

  modport source (output valid, output input_value, input ready);
  modport sink   (input valid, input input_value, output ready);
endinterface

interface swot_out_if;
  import swot_pkg::*;
  logic valid;
  logic ready;
  nib_t output_value;
  wt_t  rel_weight;
  wt_t  min_weight;
  wt_t  max_weight;
  logic found;
  logic last;

  modport source (output valid, output output_value, output rel_weight,
                  output min_weight, output max_weight, output found,
                  output last, input ready);
  modport sink   (input valid, input output_value, input rel_weight,
                  input min_weight, input max_weight, input found,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== sv/swot_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swot_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output swot_pkg::sbox_t   sbox_o,
  output swot_pkg::mode_e   mode_o
);
  import swot_pkg::*;

  sbox_t sbox_q, sbox_d;
  mode_e mode_q, mode_d;
  reg_e  reg_sel;
  logic  wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    sbox_d = sbox_q;
    mode_d = mode_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_SBOX: sbox_d = pwdata;
        REG_MODE: mode_d = mode_e'(pwdata[0]);
        default:  sbox_d = sbox_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SBOX: prdata = sbox_q;
      REG_MODE: prdata = {63'd0, mode_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbox_q <= SboxReset;
      mode_q <= MODE_DDT;
    end else begin
      sbox_q <= sbox_d;
      mode_q <= mode_d;
    end
  end

  assign sbox_o = sbox_q;
  assign mode_o = mode_q;

endmodule

`default_nettype wire

// ===== sv/swot_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swot_match (
  input  logic             clk_i,
  input  logic             rst_ni,
  swot_in_if.sink          in_i,
  input  swot_pkg::sbox_t  sbox_i,
  input  swot_pkg::mode_e  mode_i,
  output logic             valid_o,
  input  logic             ready_i,
  output swot_pkg::match_t match_o,
  output swot_pkg::mode_e  mode_o
);
  import swot_pkg::*;

  logic   s1_valid_q, s1_ready;
  nib_t   s1_row_q;
  mode_e  s1_mode_q;

  logic   s2_valid_q, s2_ready;
  match_t s2_match_q, match_d;
  mode_e  s2_mode_q;

  assign s2_ready   = !s2_valid_q || ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  // Entry [j][x] marks that x contributes to the count of output j.
  always_comb begin
    match_d = '0;
    for (int j = 0; j < NumVals; j++) begin
      for (int x = 0; x < NumVals; x++) begin
        if (s1_mode_q == MODE_DDT) begin
          match_d[j][x] = ((sbox_i[x] ^ sbox_i[nib_t'(x) ^ s1_row_q]) == nib_t'(j));
        end else begin
          match_d[j][x] = (parity4(nib_t'(x) & s1_row_q) ==
                           parity4(sbox_i[x] & nib_t'(j)));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_row_q  <= in_i.input_value;
      s1_mode_q <= mode_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_match_q <= match_d;
      s2_mode_q  <= s1_mode_q;
    end
  end

  assign valid_o = s2_valid_q;
  assign match_o = s2_match_q;
  assign mode_o  = s2_mode_q;

endmodule

`default_nettype wire

// ===== sv/swot_weigh.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swot_weigh (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  swot_pkg::match_t match_i,
  input  swot_pkg::mode_e  mode_i,
  output logic             valid_o,
  input  logic             ready_i,
  output swot_pkg::row_t   row_o
);
  import swot_pkg::*;

  logic                s3_valid_q, s3_ready;
  lvl_e [NumVals-1:0]  s3_lvl_q, lvl_d;
  mode_e               s3_mode_q;

  logic                s4_valid_q, s4_ready;
  row_t                s4_row_q, row_d;
  logic [NumLvls-1:0]  has_lvl;
  lvl_e                min_lvl, max_lvl;

  assign s4_ready = !s4_valid_q || ready_i;
  assign s3_ready = !s3_valid_q || s4_ready;
  assign ready_o  = s3_ready;

  always_comb begin
    for (int j = 0; j < NumVals; j++) begin
      lvl_d[j] = count_level(popcount16(match_i[j]), mode_i);
    end
  end

  // Sort into per-level masks laid out in tie order.
  always_comb begin
    row_d = '0;
    for (int k = 0; k < NumLvls; k++) begin
      for (int p = 0; p < NumVals; p++) begin
        row_d.mask[k][p] = (s3_lvl_q[TieOrder[p]] == lvl_e'(k));
      end
      has_lvl[k] = |row_d.mask[k];
    end

    priority if (has_lvl[0]) min_lvl = LVL_0;
    else if (has_lvl[1])     min_lvl = LVL_1;
    else if (has_lvl[2])     min_lvl = LVL_2;
    else                     min_lvl = LVL_NONE;

    priority if (has_lvl[2]) max_lvl = LVL_2;
    else if (has_lvl[1])     max_lvl = LVL_1;
    else if (has_lvl[0])     max_lvl = LVL_0;
    else                     max_lvl = LVL_NONE;

    row_d.min_w = lvl_weight(min_lvl, s3_mode_q);
    row_d.max_w = lvl_weight(max_lvl, s3_mode_q);
    for (int k = 0; k < NumLvls; k++) begin
      row_d.rel_w[k] = lvl_weight(lvl_e'(k), s3_mode_q) - row_d.min_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s3_ready) s3_valid_q <= valid_i;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && valid_i) begin
      s3_lvl_q  <= lvl_d;
      s3_mode_q <= mode_i;
    end
    if (s4_ready && s3_valid_q) begin
      s4_row_q <= row_d;
    end
  end

  assign valid_o = s4_valid_q;
  assign row_o   = s4_row_q;

endmodule

`default_nettype wire

// ===== sv/swot_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swot_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  swot_pkg::row_t row_i,
  swot_out_if.source     out_o
);
  import swot_pkg::*;

  logic               act_q, act_d;
  row_t               row_q, row_d;
  logic [NumLvls-1:0] has_lvl;
  logic [1:0]         sel_k;
  vec_t               cur;
  nib_t               pos;
  logic [NumLvls-1:0][NumVals-1:0] mask_nx;
  logic               is_last, is_found;
  logic               out_load, emit_fire, done, load_new;

  logic ov_q;
  nib_t val_q;
  wt_t  rel_q, min_q, max_q;
  logic found_q, last_q;

  always_comb begin
    for (int k = 0; k < NumLvls; k++) begin
      has_lvl[k] = |row_q.mask[k];
    end
    priority if (has_lvl[0]) sel_k = 2'd0;
    else if (has_lvl[1])     sel_k = 2'd1;
    else if (has_lvl[2])     sel_k = 2'd2;
    else                     sel_k = 2'd0;

    cur = row_q.mask[sel_k];
    pos = '0;
    for (int p = NumVals - 1; p >= 0; p--) begin
      if (cur[p]) pos = nib_t'(p);
    end

    mask_nx             = row_q.mask;
    mask_nx[sel_k][pos] = 1'b0;
    is_last             = (mask_nx == '0);
    is_found            = |has_lvl;
  end

  assign out_load  = !ov_q || out_o.ready;
  assign emit_fire = act_q && out_load;
  assign done      = emit_fire && is_last;
  assign ready_o   = !act_q || done;
  assign load_new  = valid_i && ready_o;

  always_comb begin
    row_d = row_q;
    act_d = act_q;
    if (load_new) begin
      row_d = row_i;
      act_d = 1'b1;
    end else if (emit_fire) begin
      row_d.mask = mask_nx;
      act_d      = !is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      if (out_load) ov_q <= emit_fire;
    end
  end

  // An empty row leaves as one result with found low, last high and all other fields zero.
  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    if (emit_fire) begin
      val_q   <= is_found ? TieOrder[pos] : nib_t'(0);
      rel_q   <= is_found ? row_q.rel_w[sel_k] : wt_t'(0);
      min_q   <= row_q.min_w;
      max_q   <= row_q.max_w;
      found_q <= is_found;
      last_q  <= is_last;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.output_value = val_q;
  assign out_o.rel_weight   = rel_q;
  assign out_o.min_weight   = min_q;
  assign out_o.max_weight   = max_q;
  assign out_o.found        = found_q;
  assign out_o.last         = last_q;

endmodule

`default_nettype wire

// ===== sv/sbox_weight_ordered_transitions.sv =====
// Weight-ordered transitions of a configurable 4-bit S-box.
// in_i carries one input difference (mode DDT) or input mask (mode LAT);
// out_o returns the transitions of that table row whose count maps to a
// weight, lowest weight first, equal weights in Hamming order of the
// output value; last marks the final result of a row. A row without any
// weighted entry returns one result with found low and last high.
// The APB port holds the S-box (byte address 0) and the mode (address 8);
// write them only while no transaction is in flight.
// Four register stages (row capture, match matrix, counts to levels,
// per-level masks) feed an emitter that sends one result per cycle while
// the receiver is ready; a row has 1 to 16 results, and the emitter sets
// the sustained rate. Inputs keep entering while earlier rows drain.
// Reset loads the default S-box and DDT mode and empties every stage.
// A stalled receiver holds the output register; the stages behind it fill
// and then drop in_i.ready, and nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module sbox_weight_ordered_transitions (
  input  logic        clk_i,
  input  logic        rst_ni,
  swot_in_if.sink     in_i,
  swot_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import swot_pkg::*;

  sbox_t  sbox;
  mode_e  mode;
  logic   m_valid, m_ready;
  match_t m_match;
  mode_e  m_mode;
  logic   w_valid, w_ready;
  row_t   w_row;

  swot_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sbox_o  (sbox),
    .mode_o  (mode)
  );

  swot_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .sbox_i  (sbox),
    .mode_i  (mode),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .match_o (m_match),
    .mode_o  (m_mode)
  );

  swot_weigh u_weigh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .ready_o (m_ready),
    .match_i (m_match),
    .mode_i  (m_mode),
    .valid_o (w_valid),
    .ready_i (w_ready),
    .row_o   (w_row)
  );

  swot_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (w_valid),
    .ready_o (w_ready),
    .row_i   (w_row),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.found |-> out_o.last && out_o.output_value == '0)
    else $error("empty-row result not marked last");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.found |->
      ({1'b0, out_o.rel_weight} + {1'b0, out_o.min_weight}) <= {1'b0, out_o.max_weight})
    else $error("result weight outside the row range");

  a_row_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last |=>
      out_o.valid && out_o.found && out_o.rel_weight >= $past(out_o.rel_weight) &&
      $stable(out_o.min_weight) && $stable(out_o.max_weight))
    else $error("row results out of order or interrupted");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import swot_pkg::*;

  typedef struct packed {
    nib_t out_val;
    wt_t  rel_w;
    wt_t  min_w;
    wt_t  max_w;
    logic found;
    logic last;
  } transition_t;

  typedef struct {
    logic [63:0] sbox;
    mode_e       mode;
    nib_t        in_val;
    logic        typed;
    transition_t want;
  } row_step_t;

  localparam int          WatchdogLimit = 2000;
  localparam logic [63:0] PresentSbox   = 64'h21748FE3DA09B65C;
  localparam logic [63:0] AndSbox       = 64'h1000_1000_1000_1000;
  localparam logic [3:0]  SboxAddr      = {REG_SBOX, 3'b000};
  localparam logic [3:0]  ModeAddr      = {REG_MODE, 3'b000};

  localparam transition_t OnlyZero = '{4'h0, 3'd0, 3'd0, 3'd0, 1'b1, 1'b1};
  localparam transition_t EmptyRow = '{4'h0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b1};

  localparam nib_t HammingOrder [16] = '{
    4'h0, 4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h5, 4'h6,
    4'h9, 4'ha, 4'hc, 4'h7, 4'hb, 4'hd, 4'he, 4'hf
  };

  row_step_t directed_steps [19] = '{
    '{PresentSbox, MODE_DDT, 4'h0, 1'b1, OnlyZero},
    '{PresentSbox, MODE_DDT, 4'hf, 1'b0, '0},
    '{PresentSbox, MODE_DDT, 4'h1, 1'b0, '0},
    '{PresentSbox, MODE_DDT, 4'h8, 1'b0, '0},
    '{PresentSbox, MODE_DDT, 4'h5, 1'b0, '0},
    '{PresentSbox, MODE_LAT, 4'h0, 1'b1, OnlyZero},
    '{PresentSbox, MODE_LAT, 4'hf, 1'b0, '0},
    '{PresentSbox, MODE_LAT, 4'h3, 1'b0, '0},
    '{PresentSbox, MODE_LAT, 4'ha, 1'b0, '0},
    '{64'h0,       MODE_DDT, 4'h0, 1'b1, OnlyZero},
    '{64'h0,       MODE_DDT, 4'h7, 1'b1, OnlyZero},
    '{64'h0,       MODE_LAT, 4'h0, 1'b0, '0},
    '{64'h0,       MODE_LAT, 4'h6, 1'b1, EmptyRow},
    '{'1,          MODE_LAT, 4'h0, 1'b0, '0},
    '{'1,          MODE_LAT, 4'h9, 1'b1, EmptyRow},
    '{AndSbox,     MODE_DDT, 4'h1, 1'b1, EmptyRow},
    '{AndSbox,     MODE_DDT, 4'h2, 1'b1, EmptyRow},
    '{AndSbox,     MODE_DDT, 4'h3, 1'b0, '0},
    '{AndSbox,     MODE_DDT, 4'h4, 1'b1, OnlyZero}
  };

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  swot_in_if  in_ch ();
  swot_out_if out_ch ();

  sbox_weight_ordered_transitions dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [63:0]  cfg_sbox;
  mode_e        cfg_mode;
  transition_t  expected_transitions [$];
  transition_t  got_tr;
  transition_t  want_tr;
  int           errors;
  int           idle_cycles;
  bit           tx_gaps;
  bit           rx_stalls;
  int           long_hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  function automatic nib_t sbox_nib(input int x);
    return cfg_sbox[4*(x & 15) +: 4];
  endfunction

  // Build the weighted row for in_val and queue its transitions in emit order.
  function automatic void predict_transitions(input nib_t in_val);
    int          hits [16];
    int          wgt [16];
    int          lvl_w [3];
    int          dev;
    nib_t        v;
    nib_t        order_val [$];
    int          order_w [$];
    transition_t t;
    for (int j = 0; j < 16; j++) hits[j] = 0;
    if (cfg_mode == MODE_DDT) begin
      for (int x = 0; x < 16; x++) hits[sbox_nib(x) ^ sbox_nib(x ^ in_val)]++;
      lvl_w[0] = 0; lvl_w[1] = 2; lvl_w[2] = 3;
    end else begin
      for (int j = 0; j < 16; j++)
        for (int x = 0; x < 16; x++)
          if (^(nib_t'(x) & in_val) == ^(sbox_nib(x) & nib_t'(j))) hits[j]++;
      lvl_w[0] = 0; lvl_w[1] = 2; lvl_w[2] = 4;
    end
    for (int j = 0; j < 16; j++) begin
      wgt[j] = -1;
      if (cfg_mode == MODE_DDT) begin
        if (hits[j] == 16) wgt[j] = 0;
        else if (hits[j] == 4) wgt[j] = 2;
        else if (hits[j] == 2) wgt[j] = 3;
      end else begin
        dev = (hits[j] >= 8) ? hits[j] - 8 : 8 - hits[j];
        if (dev == 8) wgt[j] = 0;
        else if (dev == 4) wgt[j] = 2;
        else if (dev == 2) wgt[j] = 4;
      end
    end
    for (int k = 0; k < 3; k++)
      for (int p = 0; p < 16; p++) begin
        v = HammingOrder[p];
        if (wgt[v] == lvl_w[k]) begin
          order_val.push_back(v);
          order_w.push_back(lvl_w[k]);
        end
      end
    if (order_val.size() == 0) begin
      expected_transitions.push_back(EmptyRow);
      return;
    end
    for (int k = 0; k < order_val.size(); k++) begin
      t.out_val = order_val[k];
      t.rel_w   = wt_t'(order_w[k] - order_w[0]);
      t.min_w   = wt_t'(order_w[0]);
      t.max_w   = wt_t'(order_w[order_w.size()-1]);
      t.found   = 1'b1;
      t.last    = (k == order_val.size() - 1);
      expected_transitions.push_back(t);
    end
  endfunction

  function automatic logic [63:0] random_perm_sbox();
    nib_t        ent [16];
    nib_t        tmp;
    int          k;
    logic [63:0] s;
    for (int i = 0; i < 16; i++) ent[i] = nib_t'(i);
    for (int i = 15; i > 0; i--) begin
      k      = $urandom_range(0, i);
      tmp    = ent[i];
      ent[i] = ent[k];
      ent[k] = tmp;
    end
    for (int i = 0; i < 16; i++) s[4*i +: 4] = ent[i];
    return s;
  endfunction

  task automatic apb_xfer(input logic wr, input logic [3:0] addr, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [3:0] addr, input logic [63:0] want);
    logic [63:0] rd;
    apb_xfer(1'b0, addr, 64'h0, rd);
    if (rd !== want) report("register readback", want, rd);
  endtask

  task automatic configure(input logic [63:0] sbox, input mode_e mode);
    logic [63:0] rd;
    apb_xfer(1'b1, SboxAddr, sbox, rd);
    reg_check(SboxAddr, sbox);
    apb_xfer(1'b1, ModeAddr, {63'b0, mode}, rd);
    reg_check(ModeAddr, {63'b0, mode});
    cfg_sbox = sbox;
    cfg_mode = mode;
  endtask

  // Wait out every pending transition, then let the pipeline go idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_transitions.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_row(input nib_t in_val, input logic typed, input transition_t want);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.input_value <= in_val;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) expected_transitions.push_back(want);
    else predict_transitions(in_val);
  endtask

  // Receiver: random stall bursts, plus a long hold when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req > 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      got_tr = {out_ch.output_value, out_ch.rel_weight, out_ch.min_weight,
                out_ch.max_weight, out_ch.found, out_ch.last};
      if (expected_transitions.size() == 0) begin
        errors++;
        $display("%0t: transaction with nothing pending, expected none, got %0h",
                 $time, got_tr);
      end else begin
        want_tr = expected_transitions.pop_front();
        if (got_tr.out_val !== want_tr.out_val)
          report("output_value", want_tr.out_val, got_tr.out_val);
        if (got_tr.rel_w !== want_tr.rel_w) report("rel_weight", want_tr.rel_w, got_tr.rel_w);
        if (got_tr.min_w !== want_tr.min_w) report("min_weight", want_tr.min_w, got_tr.min_w);
        if (got_tr.max_w !== want_tr.max_w) report("max_weight", want_tr.max_w, got_tr.max_w);
        if (got_tr.found !== want_tr.found) report("found", want_tr.found, got_tr.found);
        if (got_tr.last !== want_tr.last) report("last", want_tr.last, got_tr.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] nxt_sbox;
    mode_e       nxt_mode;
    errors        = 0;
    idle_cycles   = 0;
    long_hold_req = 0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    cfg_sbox      = PresentSbox;
    cfg_mode      = MODE_DDT;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.input_value <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_check(SboxAddr, PresentSbox);
    reg_check(ModeAddr, 64'h0);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].sbox !== cfg_sbox || directed_steps[i].mode !== cfg_mode) begin
        drain();
        configure(directed_steps[i].sbox, directed_steps[i].mode);
      end
      send_row(directed_steps[i].in_val, directed_steps[i].typed, directed_steps[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 2) nxt_sbox = PresentSbox;
      else if (ph == 4 || ph == 5) nxt_sbox = {$urandom(), $urandom()};
      else nxt_sbox = random_perm_sbox();
      nxt_mode = (ph == 6) ? mode_e'($urandom_range(0, 1)) : mode_e'(ph[0]);
      drain();
      configure(nxt_sbox, nxt_mode);
      tx_gaps   = (ph < 7) && ($urandom_range(0, 3) != 0);
      rx_stalls = (ph < 7) && ($urandom_range(0, 3) != 0);
      // Hold the receiver off while rows keep coming, to back up the pipeline.
      if (ph == 1) begin
        tx_gaps       = 1'b0;
        long_hold_req = 300;
      end
      repeat (25) send_row(nib_t'($urandom_range(0, 15)), 1'b0, '0);
    end

    drain();
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/swot_pkg.sv
sv/swot_if.sv
sv/swot_regs.sv
sv/swot_match.sv
sv/swot_weigh.sv
sv/swot_emit.sv
sv/sbox_weight_ordered_transitions.sv
verif/tb.sv
